/* rtl/core/cpr_pkg.sv */
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared constants for the clock page replacement block.
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam int OCC_W  = 4;
    localparam int VICT_W = 20;
    localparam int CFG_W  = 4;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_FAULT  = 1'b1;

endpackage

/* rtl/core/cpr_if.sv */
// ----------------------------------------------------------------------------
// cpr_if
// Channels of the clock page replacement block: item in, result out, config.
// ----------------------------------------------------------------------------
interface cpr_in_if #(parameter int PAGE_BITS = 20);
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [PAGE_BITS-1:0] page_number;

    modport source (output valid, output kind, output page_number, input ready);
    modport sink   (input valid, input kind, input page_number, output ready);
endinterface

interface cpr_out_if;
    import cpr_pkg::*;
    logic              valid;
    logic              ready;
    logic              hit;
    logic              evicted;
    logic [VICT_W-1:0] victim_page;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, output hit, output evicted, output victim_page,
                    output occupancy, input ready);
    modport sink   (input valid, input hit, input evicted, input victim_page,
                    input occupancy, output ready);
endinterface

interface cpr_cfg_if;
    import cpr_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/clock_page_replacement.sv */
// ----------------------------------------------------------------------------
// clock_page_replacement
// Second chance working set: a ring of page slots with reference bits and a
// clock hand, walked one slot per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// Sequence from accept to the result beat: a fault into a free slot writes it
// and goes to done; an access scans the filled slots, one slot compared a cycle;
// an eviction sweeps, clearing set bits, then captures the victim. Output stalls hold done.
// Throughput: one item at a time; the next beat is taken once the sequencer
// is back in idle, while the previous result may still wait at the output.
// Reset: reference bits, hand and fill count clear, active size returns to 8.
// ----------------------------------------------------------------------------
module clock_page_replacement
    import cpr_pkg::*;
#(
    parameter int SLOTS     = 8,
    parameter int PAGE_BITS = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cpr_in_if.sink    i_item,
    cpr_out_if.source o_result,
    cpr_cfg_if.sink   i_cfg
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_VCAP  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    function automatic logic [SLOT_W-1:0] adv(input logic [SLOT_W-1:0] h,
                                              input logic [CNT_W-1:0]  n);
        logic [CNT_W-1:0] nx;
        nx = CNT_W'(h) + 1'b1;
        adv = (nx == n) ? '0 : nx[SLOT_W-1:0];
    endfunction

    // control state
    logic [2:0]        r_state,     n_state;
    logic [CNT_W-1:0]  r_fill,      n_fill;
    logic [SLOT_W-1:0] r_hand,      n_hand;
    logic [SLOTS-1:0]  r_ref,       n_ref;
    logic [CFG_W-1:0]  r_active;
    logic              r_out_valid, n_out_valid;
    logic              r_cmp_vld,   n_cmp_vld;

    // working registers
    logic [PAGE_BITS-1:0] r_page;
    logic [CNT_W-1:0]     r_idx,     n_idx;
    logic [CNT_W-1:0]     r_steps,   n_steps;
    logic [SLOT_W-1:0]    r_h,       n_h;
    logic [SLOT_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic                 r_hit,     n_hit;
    logic                 r_evict,   n_evict;
    logic [VICT_W-1:0]    r_victim,  n_victim;

    // output register
    logic              r_o_hit;
    logic              r_o_evict;
    logic [VICT_W-1:0] r_o_victim;
    logic [OCC_W-1:0]  r_o_occ;

    // page store
    logic [PAGE_BITS-1:0] mem_page [SLOTS];
    logic [PAGE_BITS-1:0] r_rd_data;
    logic                 mem_re;
    logic [SLOT_W-1:0]    mem_raddr;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_waddr;
    logic [PAGE_BITS-1:0] mem_wdata;

    logic [CMP_W-1:0] eff_active;
    logic             accept;
    logic             out_load;
    logic             issue;
    logic             has_room;

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign accept       = i_item.valid && (r_state == S_IDLE);

    assign o_result.valid       = r_out_valid;
    assign o_result.hit         = r_o_hit;
    assign o_result.evicted     = r_o_evict;
    assign o_result.victim_page = r_o_victim;
    assign o_result.occupancy   = r_o_occ;

    // active size: zero reads as one, saturate at the ring size
    always_comb begin
        if (r_active == '0) begin
            eff_active = CMP_W'(1);
        end else if (CMP_W'(r_active) > CMP_W'(SLOTS)) begin
            eff_active = CMP_W'(SLOTS);
        end else begin
            eff_active = CMP_W'(r_active);
        end
    end

    assign has_room = CMP_W'(r_fill) < eff_active;
    assign issue    = (r_idx < r_fill);
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_result.ready);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_hand      = r_hand;
        n_ref       = r_ref;
        n_out_valid = r_out_valid && !o_result.ready;
        n_cmp_vld   = 1'b0;
        n_idx       = r_idx;
        n_steps     = r_steps;
        n_h         = r_h;
        n_cmp_idx   = r_cmp_idx;
        n_hit       = r_hit;
        n_evict     = r_evict;
        n_victim    = r_victim;
        mem_re      = 1'b0;
        mem_raddr   = r_h;
        mem_we      = 1'b0;
        mem_waddr   = r_h;
        mem_wdata   = r_page;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_hit    = 1'b0;
                    n_evict  = 1'b0;
                    n_victim = '0;
                    if (i_item.kind == KIND_ACCESS) begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end else if (has_room) begin
                        mem_we                       = 1'b1;
                        mem_waddr                    = r_fill[SLOT_W-1:0];
                        mem_wdata                    = i_item.page_number;
                        n_ref[r_fill[SLOT_W-1:0]]    = 1'b1;
                        n_fill                       = r_fill + 1'b1;
                        n_state                      = S_DONE;
                    end else begin
                        n_h     = r_hand;
                        n_steps = '0;
                        n_state = S_SWEEP;
                    end
                end
            end
            S_SCAN: begin
                // read one slot a cycle, compare the one read the cycle before
                if (issue) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx[SLOT_W-1:0];
                    n_idx     = r_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[SLOT_W-1:0];
                end
                if (r_cmp_vld && (r_rd_data == r_page)) begin
                    n_ref[r_cmp_idx] = 1'b1;
                    n_hit            = 1'b1;
                end
                if (!issue && !r_cmp_vld) begin
                    n_state = S_DONE;
                end
            end
            S_SWEEP: begin
                // a full turn lands back on the starting slot
                if ((r_steps == r_fill) || !r_ref[r_h]) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_h;
                    n_state   = S_VCAP;
                end else begin
                    n_ref[r_h] = 1'b0;
                    n_h        = adv(r_h, r_fill);
                    n_steps    = r_steps + 1'b1;
                end
            end
            S_VCAP: begin
                n_victim   = VICT_W'(r_rd_data);
                n_evict    = 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = r_h;
                n_ref[r_h] = 1'b1;
                n_hand     = adv(r_h, r_fill);
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_hand      <= '0;
            r_ref       <= '0;
            r_active    <= ACTIVE_RESET;
            r_out_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_hand      <= n_hand;
            r_ref       <= n_ref;
            r_out_valid <= n_out_valid;
            r_cmp_vld   <= n_cmp_vld;
            if (i_cfg.valid) begin
                r_active <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page <= i_item.page_number;
        end
        r_idx     <= n_idx;
        r_steps   <= n_steps;
        r_h       <= n_h;
        r_cmp_idx <= n_cmp_idx;
        r_hit     <= n_hit;
        r_evict   <= n_evict;
        r_victim  <= n_victim;
        if (out_load) begin
            r_o_hit    <= r_hit;
            r_o_evict  <= r_evict;
            r_o_victim <= r_victim;
            r_o_occ    <= OCC_W'(r_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_page[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem_page[mem_raddr];
        end
    end

endmodule

/* tb/clock_page_replacement_tb.sv */
// ----------------------------------------------------------------------------
// clock_page_replacement_tb
// Self-checking bench for the second chance working set. Directed rows cover
// the empty set, extreme page numbers, duplicate faults and changes of the
// active size. Random phases follow, each with its own active size. Every
// result beat is compared field by field with a written expectation or a
// model of the ring, its reference bits and the clock hand.
// ----------------------------------------------------------------------------
module clock_page_replacement_tb;
    import cpr_pkg::*;

    localparam int SLOTS        = 8;
    localparam int PAGE_W       = 20;
    localparam int CFG_SETTLE   = SLOTS + 4;
    localparam int TAIL_CYCLES  = SLOTS + 4;
    localparam int LONG_HOLD    = 150;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 65;
    localparam int DRAIN_ITEMS  = 15;
    localparam int POOL_SIZE    = 11;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic              hit;
        logic              evicted;
        logic [VICT_W-1:0] victim;
        logic [OCC_W-1:0]  occupancy;
    } t_page_outcome;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;

    typedef struct {
        t_row_op          op;
        logic             kind;
        logic [PAGE_W-1:0] page;
        logic             typed;
        t_page_outcome    want;
        logic [CFG_W-1:0] active;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    cpr_in_if #(.PAGE_BITS(PAGE_W)) item_if ();
    cpr_out_if                      result_if ();
    cpr_cfg_if                      cfg_if ();

    clock_page_replacement #(
        .SLOTS     (SLOTS),
        .PAGE_BITS (PAGE_W)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    // Model of the working set
    logic [PAGE_W-1:0] ws_page [SLOTS];
    logic              ws_ref  [SLOTS];
    int unsigned       ws_hand;
    int unsigned       ws_fill;
    logic [CFG_W-1:0]  ws_active;

    t_page_outcome     pending_outcomes [$];
    t_dir_row          dir_rows [$];
    logic [PAGE_W-1:0] page_pool [POOL_SIZE];

    int  error_count;
    int  cycle_count;
    bit  calm;
    bit  hold_req;

    initial i_clk = 1'b0;

    always #2 i_clk = ~i_clk;

    function automatic t_page_outcome apply_page_ref(input logic k,
                                                     input logic [PAGE_W-1:0] pg);
        t_page_outcome r;
        int unsigned   lim;
        int unsigned   n;
        int unsigned   h;
        r   = '0;
        lim = (ws_active == '0) ? 1 :
              ((int'(ws_active) > SLOTS) ? SLOTS : int'(ws_active));
        if (k == KIND_ACCESS) begin
            for (int i = 0; i < ws_fill; i++) begin
                if (ws_page[i] == pg) begin
                    ws_ref[i] = 1'b1;
                    r.hit     = 1'b1;
                end
            end
        end else if (ws_fill < lim) begin
            ws_page[ws_fill] = pg;
            ws_ref[ws_fill]  = 1'b1;
            ws_fill++;
        end else begin
            n = ws_fill;
            h = ws_hand % n;
            // sweep at most one turn, giving each referenced slot its second chance
            for (int i = 0; i < n && ws_ref[h]; i++) begin
                ws_ref[h] = 1'b0;
                h = (h + 1) % n;
            end
            r.evicted  = 1'b1;
            r.victim   = ws_page[h];
            ws_page[h] = pg;
            ws_ref[h]  = 1'b1;
            ws_hand    = (h + 1) % n;
        end
        r.occupancy = OCC_W'(ws_fill);
        return r;
    endfunction

    function automatic t_dir_row item_row(input logic k, input logic [PAGE_W-1:0] pg);
        t_dir_row r;
        r        = '{op: ROW_ITEM, default: '0};
        r.kind   = k;
        r.page   = pg;
        return r;
    endfunction

    function automatic t_dir_row typed_row(input logic k, input logic [PAGE_W-1:0] pg,
                                           input logic hit, input logic ev,
                                           input logic [VICT_W-1:0] vic,
                                           input logic [OCC_W-1:0] occ);
        t_dir_row r;
        r       = item_row(k, pg);
        r.typed = 1'b1;
        r.want  = '{hit: hit, evicted: ev, victim: vic, occupancy: occ};
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input logic [CFG_W-1:0] v);
        t_dir_row r;
        r        = '{op: ROW_CFG, default: '0};
        r.active = v;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0d] mismatch on %s: got %0h, expected %0h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    task automatic send_item(input logic k, input logic [PAGE_W-1:0] pg,
                             input logic typed, input t_page_outcome want);
        t_page_outcome predicted;
        item_if.valid       <= 1'b1;
        item_if.kind        <= k;
        item_if.page_number <= pg;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        predicted = apply_page_ref(k, pg);
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    task automatic pause_items(input int n);
        item_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drain();
        item_if.valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_active(input logic [CFG_W-1:0] v);
        wait_drain();
        // let the sequencer finish its last slot update
        repeat (CFG_SETTLE) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        ws_active = v;
    endtask

    task automatic send_random_item();
        logic             k;
        logic [PAGE_W-1:0] pg;
        k  = ($urandom_range(0, 99) < 35) ? KIND_FAULT : KIND_ACCESS;
        pg = ($urandom_range(0, 3) != 0) ? page_pool[$urandom_range(0, POOL_SIZE - 1)]
                                         : PAGE_W'($urandom());
        send_item(k, pg, 1'b0, '0);
    endtask

    // Result side: check each beat, then choose ready for the next edge
    initial begin
        int            idle_left;
        int            hold_left;
        t_page_outcome want;
        idle_left = 0;
        hold_left = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_if.valid && result_if.ready) begin
                if (pending_outcomes.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding", 32'd1, 32'd0);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (result_if.hit !== want.hit)
                        report_mismatch("hit", 32'(result_if.hit), 32'(want.hit));
                    if (result_if.evicted !== want.evicted)
                        report_mismatch("evicted", 32'(result_if.evicted),
                                        32'(want.evicted));
                    if (result_if.victim_page !== want.victim)
                        report_mismatch("victim_page", 32'(result_if.victim_page),
                                        32'(want.victim));
                    if (result_if.occupancy !== want.occupancy)
                        report_mismatch("occupancy", 32'(result_if.occupancy),
                                        32'(want.occupancy));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD - 1;
                result_if.ready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                result_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                idle_left = $urandom_range(1, 10) - 1;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_dir_row row;
        logic [CFG_W-1:0] phase_active;

        error_count = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            ws_page[i] = '0;
            ws_ref[i]  = 1'b0;
        end
        ws_hand   = 0;
        ws_fill   = 0;
        ws_active = ACTIVE_RESET;

        item_if.valid       <= 1'b0;
        item_if.kind        <= KIND_ACCESS;
        item_if.page_number <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.data         <= '0;
        i_rst_n             <= 1'b0;

        // empty set, then an active size of zero behaving as one slot
        dir_rows.push_back(typed_row(KIND_ACCESS, 20'h00000, 1'b0, 1'b0, '0, 4'd0));
        dir_rows.push_back(typed_row(KIND_ACCESS, 20'hFFFFF, 1'b0, 1'b0, '0, 4'd0));
        dir_rows.push_back(cfg_row(4'd0));
        dir_rows.push_back(typed_row(KIND_FAULT,  20'hFFFFF, 1'b0, 1'b0, '0, 4'd1));
        dir_rows.push_back(typed_row(KIND_ACCESS, 20'hFFFFF, 1'b1, 1'b0, '0, 4'd1));
        dir_rows.push_back(typed_row(KIND_FAULT,  20'h00000, 1'b0, 1'b1, 20'hFFFFF, 4'd1));
        dir_rows.push_back(typed_row(KIND_FAULT,  20'h00000, 1'b0, 1'b1, 20'h00000, 4'd1));
        // raise after eviction began; duplicate page goes to another slot
        dir_rows.push_back(cfg_row(4'd3));
        dir_rows.push_back(typed_row(KIND_FAULT,  20'h00000, 1'b0, 1'b0, '0, 4'd2));
        dir_rows.push_back(typed_row(KIND_ACCESS, 20'h00000, 1'b1, 1'b0, '0, 4'd2));
        dir_rows.push_back(typed_row(KIND_FAULT,  20'hAAAAA, 1'b0, 1'b0, '0, 4'd3));
        dir_rows.push_back(item_row(KIND_FAULT,  20'h55555));
        dir_rows.push_back(item_row(KIND_ACCESS, 20'h55555));
        // oversized active size saturates at the slot count
        dir_rows.push_back(cfg_row(4'd15));
        dir_rows.push_back(item_row(KIND_FAULT,  20'h80000));
        dir_rows.push_back(item_row(KIND_FAULT,  20'h7FFFF));
        dir_rows.push_back(item_row(KIND_FAULT,  20'h00001));
        dir_rows.push_back(item_row(KIND_FAULT,  20'h12345));
        dir_rows.push_back(item_row(KIND_FAULT,  20'hEDCBA));
        dir_rows.push_back(item_row(KIND_FAULT,  20'h3C3C3));
        dir_rows.push_back(item_row(KIND_ACCESS, 20'h7FFFF));
        // lowered below fill: evictions still pick among all filled slots
        dir_rows.push_back(cfg_row(4'd2));
        dir_rows.push_back(item_row(KIND_FAULT,  20'h0F0F0));
        dir_rows.push_back(item_row(KIND_FAULT,  20'hF0F0F));
        dir_rows.push_back(cfg_row(4'd8));
        dir_rows.push_back(item_row(KIND_ACCESS, 20'h00000));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            if (row.op == ROW_CFG)
                write_active(row.active);
            else
                send_item(row.kind, row.page, row.typed, row.want);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       phase_active = 4'd1;
                1:       phase_active = 4'd8;
                2:       phase_active = 4'd0;
                3:       phase_active = 4'd15;
                default: phase_active = CFG_W'($urandom_range(0, 15));
            endcase
            write_active(phase_active);
            calm = (phase == NUM_PHASES - 1);
            foreach (page_pool[p])
                page_pool[p] = PAGE_W'($urandom());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // stall the output for a long stretch while items keep coming
                if (phase == 2 && n == 10)
                    hold_req = 1'b1;
                send_random_item();
                if (phase == 4 && n < DRAIN_ITEMS)
                    wait_drain();
                else if (!calm && $urandom_range(0, 7) == 0)
                    pause_items($urandom_range(1, 10));
            end
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
